/* rtl/tbf_pkg.sv */
// Shared types, constants and lookup for the tach bar-graph formatter.
// No dependencies; used by every other file in rtl.
`timescale 1ns / 1ps

package tbf_pkg;

    localparam int BAR_CELLS_DEF  = 8;

    localparam int RPM_W          = 16;
    localparam int POS_W          = 6;
    localparam int BYTE_W         = 8;
    localparam int SPEED_W        = 13;   // clamped speed 0..7999
    localparam int SCALE_W        = 7;    // rpm/100, 0..79
    localparam int FULL_W         = 3;    // full blocks, 0..7
    localparam int PART_W         = 3;    // partial remainder, 0..4
    localparam int DIGIT_W        = 4;

    localparam logic [SPEED_W-1:0] RPM_MAX        = 13'd7999;
    // x/100 as (x * 5243) >> 19, exact for x below 8000
    localparam logic [SPEED_W-1:0] RECIP_100      = 13'd5243;
    localparam int                 RECIP_100_SH   = 19;
    localparam logic [POS_W-1:0]   POSITION_LIMIT = 6'd40;
    localparam logic [POS_W-1:0]   POSITION_RST   = 6'd10;

    localparam logic [BYTE_W-1:0]  CMD_SET_CURSOR = 8'h1b;
    localparam logic [BYTE_W-1:0]  CELL_FULL      = 8'h7f;
    localparam logic [BYTE_W-1:0]  CELL_BLANK     = 8'h20;
    localparam logic [BYTE_W-1:0]  DIGIT_ZERO     = 8'h30;

    // Decoded fields of one run, handed from the top level to the byte selector
    typedef struct packed {
        logic               has_cursor;
        logic [FULL_W-1:0]  full;
        logic [PART_W-1:0]  part;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_run;

    function automatic logic [BYTE_W-1:0] partial_cell(input logic [PART_W-1:0] part);
        logic [BYTE_W-1:0] code;
        unique case (part)
            3'd1:    code = 8'hf0;
            3'd2:    code = 8'hf1;
            3'd3:    code = 8'hf2;
            3'd4:    code = 8'hf3;
            default: code = CELL_BLANK;
        endcase
        return code;
    endfunction

endpackage

/* rtl/tbf_byte_sel.sv */
// Picks the display byte for a given position within a run.
// Depends on tbf_pkg (t_run, byte constants, partial_cell).
`timescale 1ns / 1ps

module tbf_byte_sel #(
    parameter int BAR_CELLS = tbf_pkg::BAR_CELLS_DEF,
    parameter int IDX_W     = $clog2(BAR_CELLS + 4)
) (
    input  tbf_pkg::t_run                    i_run,
    input  logic [IDX_W-1:0]                 i_idx,
    input  logic [tbf_pkg::POS_W-1:0]        i_pos,
    output logic [tbf_pkg::BYTE_W-1:0]       o_byte,
    output logic                             o_last
);

    logic [IDX_W-1:0] rel;

    // cell/digit index once the cursor bytes are skipped
    assign rel = i_run.has_cursor ? i_idx - IDX_W'(2) : i_idx;

    always_comb begin
        o_last = 1'b0;
        priority if (i_run.has_cursor && i_idx == IDX_W'(0)) begin
            o_byte = tbf_pkg::CMD_SET_CURSOR;
        end else if (i_run.has_cursor && i_idx == IDX_W'(1)) begin
            o_byte = tbf_pkg::BYTE_W'(i_pos);
        end else if (rel < IDX_W'(BAR_CELLS)) begin
            if (rel < IDX_W'(i_run.full)) begin
                o_byte = tbf_pkg::CELL_FULL;
            end else if (rel == IDX_W'(i_run.full)) begin
                o_byte = tbf_pkg::partial_cell(i_run.part);
            end else begin
                o_byte = tbf_pkg::CELL_BLANK;
            end
        end else if (rel == IDX_W'(BAR_CELLS)) begin
            o_byte = tbf_pkg::DIGIT_ZERO + tbf_pkg::BYTE_W'(i_run.tens);
        end else begin
            o_byte = tbf_pkg::DIGIT_ZERO + tbf_pkg::BYTE_W'(i_run.ones);
            o_last = 1'b1;
        end
    end

endmodule

/* rtl/tach_bargraph_formatter.sv */
// Top level of the tach bar-graph formatter: input stage, run sequencer, output register.
// Depends on tbf_pkg and tbf_byte_sel.
`timescale 1ns / 1ps

// Each accepted rpm beat becomes one run of display bytes, one byte per output
// beat: cursor command and position (only while bar_position is below 40), then
// BAR_CELLS bar cells, then the tens and units digits of rpm/100; o_last marks the
// final byte. With the default BAR_CELLS of 8 a run is 12 beats long (10 when the
// cursor bytes are dropped). The run sequencer feeds the single output byte register
// one byte a cycle while the output is not stalled. An input register holds the next
// speed while the current run plays out, and the next run starts in the cycle after
// the previous final byte, so an unstalled output streams without gaps. An rpm beat
// passes through the input register and the run sequencer to the output register.
// bar_position resets to 10 and should only be written while the block is idle;
// o_cfg_ready is always high.

module tach_bargraph_formatter #(
    parameter int BAR_CELLS = tbf_pkg::BAR_CELLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // speed input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [tbf_pkg::RPM_W-1:0]  i_rpm,
    // display byte output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tbf_pkg::BYTE_W-1:0]        o_display_byte,
    output logic                              o_last,
    // bar_position register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbf_pkg::POS_W-1:0]         i_cfg_data
);

    localparam int IDX_W  = $clog2(BAR_CELLS + 4);
    localparam int PROD_W = 2 * tbf_pkg::SPEED_W;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic [tbf_pkg::POS_W-1:0] r_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= tbf_pkg::POSITION_RST;
        end else if (i_cfg_valid) begin
            r_pos <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // input stage: clamp, then rpm/100 by reciprocal multiply
    // ---------------------------------------------------------------
    logic [tbf_pkg::SPEED_W-1:0] speed;
    logic [PROD_W-1:0]           speed_prod;
    logic                        in_beat;
    logic                        load;
    logic                        r_in_valid;
    logic [tbf_pkg::SCALE_W-1:0] r_in_scale;

    always_comb begin
        priority if (i_rpm[tbf_pkg::RPM_W-1]) begin
            speed = '0;
        end else if (i_rpm > $signed({3'b000, tbf_pkg::RPM_MAX})) begin
            speed = tbf_pkg::RPM_MAX;
        end else begin
            speed = i_rpm[tbf_pkg::SPEED_W-1:0];
        end
    end

    assign speed_prod = speed * tbf_pkg::RECIP_100;

    // holding register is free when empty or handing over this cycle
    assign o_in_stall = r_in_valid && !load;
    assign in_beat    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_scale <= speed_prod[tbf_pkg::RECIP_100_SH +: tbf_pkg::SCALE_W];
        end
    end

    // ---------------------------------------------------------------
    // run decode: bar = scale/2, full = bar/5, digits = scale/10
    // ---------------------------------------------------------------
    logic [5:0]  bar;
    logic [9:0]  bar_prod;     // bar * 13, >> 6 gives bar/5 for bar < 40
    logic [14:0] tens_prod;    // scale * 205, >> 11 gives scale/10 for scale < 80
    tbf_pkg::t_run n_run;

    assign bar       = r_in_scale[tbf_pkg::SCALE_W-1:1];
    assign bar_prod  = bar * 4'd13;
    assign tens_prod = r_in_scale * 8'd205;

    always_comb begin
        n_run.has_cursor = r_pos < tbf_pkg::POSITION_LIMIT;
        n_run.full       = bar_prod[6 +: tbf_pkg::FULL_W];
        n_run.part       = tbf_pkg::PART_W'(bar - 6'(n_run.full) * 6'd5);
        n_run.tens       = tens_prod[11 +: tbf_pkg::DIGIT_W];
        n_run.ones       = tbf_pkg::DIGIT_W'(r_in_scale - 7'(n_run.tens) * 7'd10);
    end

    // ---------------------------------------------------------------
    // run sequencer
    // ---------------------------------------------------------------
    tbf_pkg::t_run                r_run;
    logic                         r_busy;
    logic [IDX_W-1:0]             r_idx;
    logic                         out_adv;
    logic                         emit;
    logic [tbf_pkg::BYTE_W-1:0]   sel_byte;
    logic                         sel_last;

    tbf_byte_sel #(
        .BAR_CELLS (BAR_CELLS),
        .IDX_W     (IDX_W)
    ) u_byte_sel (
        .i_run  (r_run),
        .i_idx  (r_idx),
        .i_pos  (r_pos),
        .o_byte (sel_byte),
        .o_last (sel_last)
    );

    assign out_adv = !o_out_valid || !i_out_stall;
    assign emit    = r_busy && out_adv;
    // next run starts straight after the previous final byte
    assign load    = r_in_valid && (!r_busy || (emit && sel_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            r_busy <= !sel_last;
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run <= n_run;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic                       r_out_valid;
    logic [tbf_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_display_byte = r_out_byte;
    assign o_last         = r_out_last;

endmodule

/* rtl/tbf_checker.sv */
// Port-level checks for the tach bar-graph formatter, bound to the top level.
// Depends on tbf_pkg and tach_bargraph_formatter.
`timescale 1ns / 1ps

module tbf_checker #(
    parameter int BAR_CELLS = tbf_pkg::BAR_CELLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [tbf_pkg::BYTE_W-1:0]        o_display_byte,
    input  logic                              o_last
);

    localparam int CNT_W = $clog2(BAR_CELLS + 5);

    logic             out_beat;
    logic [CNT_W-1:0] r_cnt;   // output beats seen in the current run

    assign out_beat = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (out_beat) begin
            r_cnt <= o_last ? '0 : r_cnt + CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_display_byte) && $stable(o_last))
        else $error("stalled output byte changed");

    a_run_not_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !o_last |-> r_cnt < CNT_W'(BAR_CELLS + 3))
        else $error("run overran without final byte");

    a_run_not_too_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && o_last |-> r_cnt >= CNT_W'(BAR_CELLS + 1))
        else $error("run ended early");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && o_last |->
            o_display_byte >= tbf_pkg::DIGIT_ZERO &&
            o_display_byte <= tbf_pkg::DIGIT_ZERO + 8'd9)
        else $error("final byte is not a digit");

endmodule

bind tach_bargraph_formatter tbf_checker #(.BAR_CELLS(BAR_CELLS)) u_tbf_checker (.*);

/* tb/tach_bargraph_formatter_test.sv */
// Self-checking testbench for tach_bargraph_formatter: speed beats in, display bytes out.
// Depends on tbf_pkg and the RTL; a scoreboard class predicts each run of display bytes.
`timescale 1ns / 1ps

module tach_bargraph_formatter_test;

    localparam int CELLS         = tbf_pkg::BAR_CELLS_DEF;
    localparam logic [tbf_pkg::BYTE_W-1:0] PARTIAL_FIRST = 8'hf0;   // remainder 1; 2..4 follow on
    localparam int GAP_MAX       = 17;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [tbf_pkg::BYTE_W-1:0] value;
        logic                       last;
    } t_display_beat;

    // Predicts the byte run for each accepted speed and checks output beats in order.
    class t_display_run_board;
        t_display_beat             pending_bytes[$];
        logic [tbf_pkg::POS_W-1:0] cursor_pos;
        int                        errors;

        function new();
            cursor_pos = tbf_pkg::POSITION_RST;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void put_byte(logic [tbf_pkg::BYTE_W-1:0] v);
            t_display_beat beat;
            beat.value = v;
            beat.last  = 1'b0;
            pending_bytes.push_back(beat);
        endfunction

        function void add_run(logic signed [tbf_pkg::RPM_W-1:0] rpm);
            int            speed;
            int            scale;
            int            bar;
            int            full;
            int            part;
            int            cells;
            t_display_beat tail;
            speed = rpm;
            if (speed < 0)
                speed = 0;
            if (speed > int'(tbf_pkg::RPM_MAX))
                speed = int'(tbf_pkg::RPM_MAX);
            scale = speed / 100;
            bar   = scale / 2;
            full  = bar / 5;
            part  = bar % 5;
            if (cursor_pos < tbf_pkg::POSITION_LIMIT) begin
                put_byte(tbf_pkg::CMD_SET_CURSOR);
                put_byte({2'b00, cursor_pos});
            end
            cells = 0;
            while (cells < full && cells < CELLS) begin
                put_byte(tbf_pkg::CELL_FULL);
                cells++;
            end
            // partial cell only when the full blocks left room for it
            if (cells < CELLS) begin
                if (part == 0)
                    put_byte(tbf_pkg::CELL_BLANK);
                else
                    put_byte(tbf_pkg::BYTE_W'(PARTIAL_FIRST + part - 1));
                cells++;
            end
            while (cells < CELLS) begin
                put_byte(tbf_pkg::CELL_BLANK);
                cells++;
            end
            put_byte(tbf_pkg::BYTE_W'(tbf_pkg::DIGIT_ZERO + scale / 10));
            put_byte(tbf_pkg::BYTE_W'(tbf_pkg::DIGIT_ZERO + scale % 10));
            tail      = pending_bytes.pop_back();
            tail.last = 1'b1;
            pending_bytes.push_back(tail);
        endfunction

        task match_byte(logic [tbf_pkg::BYTE_W-1:0] value, logic last);
            t_display_beat want;
            if (pending_bytes.size() == 0) begin
                report($sformatf("byte %02h with no run pending", value));
            end else begin
                want = pending_bytes.pop_front();
                if (value !== want.value)
                    report($sformatf("display byte %02h, want %02h", value, want.value));
                if (last !== want.last)
                    report($sformatf("last %b, want %b (byte %02h)", last, want.last, value));
            end
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic signed [tbf_pkg::RPM_W-1:0]  i_rpm;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [tbf_pkg::BYTE_W-1:0]        o_display_byte;
    logic                              o_last;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [tbf_pkg::POS_W-1:0]         i_cfg_data;

    t_display_run_board board;
    bit                 send_idle;   // sender inserts random gaps between beats
    bit                 take_idle;   // receiver stalls at random before each beat

    tach_bargraph_formatter #(
        .BAR_CELLS(CELLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rpm         (i_rpm),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_display_byte(o_display_byte),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every byte stalled for the longest gap).
    initial begin
        #8_000_000;
        $display("tach_bargraph_formatter_test failed");
        $finish;
    end

    // Mostly in-range speeds, some sat on the 100 rpm steps, the rest any 16-bit word
    // so that negative and over-range speeds turn up often.
    function automatic logic [tbf_pkg::RPM_W-1:0] random_speed();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return tbf_pkg::RPM_W'($urandom_range(0, 7999));
        if (pick == 6)
            return tbf_pkg::RPM_W'($urandom_range(0, 80) * 100 + $urandom_range(0, 2) - 1);
        return tbf_pkg::RPM_W'($urandom);
    endfunction

    // One speed beat. Valid stays high across back-to-back beats; the payload only
    // moves on once the beat has been taken.
    task automatic send_speed(logic [tbf_pkg::RPM_W-1:0] rpm);
        int gap;
        gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rpm      <= rpm;
        do @(posedge i_clk); while (o_in_stall);
        board.add_run(rpm);
    endtask

    // Let every predicted byte arrive, then a few cycles more so the block is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_position(logic [tbf_pkg::POS_W-1:0] pos);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pos;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.cursor_pos = pos;
    endtask

    // Output side: a fresh stall draw per beat, then take the next valid byte.
    initial begin
        int gap;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = take_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            board.match_byte(o_display_byte, o_last);
        end
    end

    initial begin
        logic [tbf_pkg::RPM_W-1:0] corner_speeds[$];
        logic [tbf_pkg::POS_W-1:0] positions[$];
        board       = new();
        send_idle   = 1'b0;
        take_idle   = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rpm       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, clamping either side, and each bar remainder and step edge,
        // all at the reset cursor position.
        corner_speeds = '{16'h8000, 16'hffff, 16'h0000, 16'd1, 16'd99, 16'd100, 16'd199,
                          16'd200, 16'd399, 16'd400, 16'd599, 16'd600, 16'd799, 16'd800,
                          16'd1000, 16'd1999, 16'd3999, 16'd5000, 16'd7800, 16'd7998,
                          16'd7999, 16'd8000, 16'h7fff, 16'h5555, 16'haaaa};
        foreach (corner_speeds[i]) begin
            if (i == 12)
                {send_idle, take_idle} = 2'b11;
            send_speed(corner_speeds[i]);
        end
        drain();

        // Cursor settings: both ends of the legal range, just past it (cursor bytes
        // dropped), all ones, a couple of random ones, and back to the reset position.
        positions = '{6'd0, 6'd39, 6'd40, 6'd63, tbf_pkg::POS_W'($urandom_range(0, 63)),
                      tbf_pkg::POS_W'($urandom_range(0, 39)), tbf_pkg::POSITION_RST};
        foreach (positions[p]) begin
            write_position(positions[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 16 == 0)
                    {send_idle, take_idle} = 2'($urandom_range(0, 3));
                send_speed(random_speed());
            end
            drain();
        end

        if (board.pending_bytes.size() != 0)
            board.report($sformatf("%0d bytes never arrived", board.pending_bytes.size()));
        if (board.errors == 0)
            $display("tach_bargraph_formatter_test passed");
        else
            $display("tach_bargraph_formatter_test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/tbf_pkg.sv
rtl/tbf_byte_sel.sv
rtl/tach_bargraph_formatter.sv
rtl/tbf_checker.sv
tb/tach_bargraph_formatter_test.sv
